// ===== design/mpq_pkg.sv =====
`default_nettype none
package mpq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic               is_empty;
        logic               is_full;
        logic               dropped;
    } result_t;

endpackage
`default_nettype wire

// ===== design/max_priority_queue_core.sv =====
`default_nettype none
// A pop ends in idle if empty or one entry is held, else ST_POP reads the new top; a push
// ends in idle if empty or full, else ST_CMP moves each larger entry up one place and writes
// the value, or ST_PUT writes it at 0. One compare unit, one memory with a read and a write port.
// One command at a time; busy stays high until done pulses, start may follow at once.
// Reset empties the queue at once; entries are never cleared; the receiver cannot stall.
module max_priority_queue_core (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    input  wire mpq_pkg::cmd_t    cmd,
    output logic                  busy,
    output logic                  done,
    output mpq_pkg::result_t      result
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_PUT  = 4'b0100,
        ST_POP  = 4'b1000
    } state_t;

    localparam logic [mpq_pkg::CNT_W-1:0] CNT_ONE  = mpq_pkg::CNT_W'(1);
    localparam logic [mpq_pkg::CNT_W-1:0] CNT_TWO  = mpq_pkg::CNT_W'(2);
    localparam logic [mpq_pkg::CNT_W-1:0] CNT_FULL = mpq_pkg::CNT_W'(mpq_pkg::DEPTH);
    localparam logic [mpq_pkg::ADDR_W-1:0] ADDR_ONE = mpq_pkg::ADDR_W'(1);
    localparam logic [mpq_pkg::ADDR_W-1:0] ADDR_TWO = mpq_pkg::ADDR_W'(2);

    logic signed [31:0] mem [mpq_pkg::DEPTH];

    state_t                       state_reg, state_next;
    logic [mpq_pkg::CNT_W-1:0]    occ_reg, occ_next;
    logic [mpq_pkg::ADDR_W-1:0]   idx_reg, idx_next;
    logic signed [31:0]           val_reg, val_next;
    logic signed [31:0]           top_reg, top_next;
    logic                         done_reg, done_next;
    mpq_pkg::result_t             result_reg, result_next;
    logic signed [31:0]           rd_data_reg;

    logic                         wr_en;
    logic [mpq_pkg::ADDR_W-1:0]   wr_addr;
    logic signed [31:0]           wr_data;
    logic [mpq_pkg::ADDR_W-1:0]   rd_addr;

    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        top_next    = top_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = val_reg;
        rd_addr     = idx_reg - ADDR_TWO;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd.kind == mpq_pkg::KIND_PUSH)
                    begin
                        if (occ_reg == CNT_FULL)
                        begin
                            done_next   = 1'b1;
                            result_next = '{top_reg, 1'b0, 1'b1, 1'b1};
                        end
                        else
                        begin
                            occ_next = occ_reg + CNT_ONE;
                            val_next = cmd.value;
                            if (occ_reg == '0 || cmd.value > top_reg)
                            begin
                                top_next = cmd.value;
                            end
                            if (occ_reg == '0)
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = '0;
                                wr_data     = cmd.value;
                                done_next   = 1'b1;
                                result_next = '{cmd.value, 1'b0, (CNT_ONE == CNT_FULL), 1'b0};
                            end
                            else
                            begin
                                idx_next   = occ_reg[mpq_pkg::ADDR_W-1:0];
                                rd_addr    = mpq_pkg::ADDR_W'(occ_reg - CNT_ONE);
                                state_next = ST_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (occ_reg == '0 || occ_reg == CNT_ONE)
                        begin
                            occ_next    = '0;
                            done_next   = 1'b1;
                            result_next = '{32'sd0, 1'b1, 1'b0, 1'b0};
                        end
                        else
                        begin
                            occ_next   = occ_reg - CNT_ONE;
                            rd_addr    = mpq_pkg::ADDR_W'(occ_reg - CNT_TWO);
                            state_next = ST_POP;
                        end
                    end
                end
            end
            ST_CMP:
            begin
                wr_en = 1'b1;
                if (rd_data_reg > val_reg)
                begin
                    wr_data  = rd_data_reg;
                    idx_next = idx_reg - ADDR_ONE;
                    if (idx_reg == ADDR_ONE)
                    begin
                        state_next = ST_PUT;
                    end
                end
                else
                begin
                    done_next   = 1'b1;
                    result_next = '{top_reg, 1'b0, (occ_reg == CNT_FULL), 1'b0};
                    state_next  = ST_IDLE;
                end
            end
            ST_PUT:
            begin
                wr_en       = 1'b1;
                done_next   = 1'b1;
                result_next = '{top_reg, 1'b0, (occ_reg == CNT_FULL), 1'b0};
                state_next  = ST_IDLE;
            end
            ST_POP:
            begin
                top_next    = rd_data_reg;
                done_next   = 1'b1;
                result_next = '{rd_data_reg, 1'b0, 1'b0, 1'b0};
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        top_reg    <= top_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire
